[rtl/gsa_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the
// generational slot allocator. No dependencies.
`default_nettype none

package gsa_pkg;

    // Table geometry
    localparam int SLOT_COUNT = 1024;
    localparam int GEN_BITS   = 16;
    localparam int IDX_W      = $clog2(SLOT_COUNT);
    localparam int WORD_W     = (SLOT_COUNT < 32) ? SLOT_COUNT : 32;
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int WORD_CNT   = SLOT_COUNT / WORD_W;
    localparam int WORD_AW    = (WORD_CNT < 2) ? 1 : $clog2(WORD_CNT);

    // Request and result field widths
    localparam int MODE_W       = 2;
    localparam int IN_IDX_W     = 16;
    localparam int IN_GEN_W     = 16;
    localparam int STATUS_W     = 2;
    localparam int RES_IDX_W    = 10;
    localparam int RES_GEN_W    = 16;
    localparam int IN_TDATA_W   = 32;
    localparam int IN_TUSER_W   = 2;
    localparam int OUT_TDATA_W  = 32;
    localparam int OUT_TUSER_W  = 3;
    localparam int IDX_EXT_W    = IN_IDX_W + 1;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CHECK = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_STALE = 2'd3;

    // Commands from controller to datapath
    typedef struct packed {
        logic clear;       // write one clearing-pass entry
        logic load;        // capture the request
        logic rd_alloc;    // read the free word picked by the summary
        logic rd_handle;   // read free word and generation of the handle
        logic take_slot;   // claim lowest free bit, read its generation
        logic alloc_done;  // latch the granted generation as the result
        logic set_full;    // result: no free slot
        logic set_range;   // result: index out of range
        logic chk_handle;  // judge the handle, release slot on a live free
        logic push_out;    // move the result into the output register
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic clear_last;
        logic is_alloc;
        logic range_bad;
        logic any_free;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

[rtl/gsa_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, hold data when not reading
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/gsa_ctrl.sv]
// Request sequencer for the slot allocator: clearing pass, decode, memory
// read waits and result hand-off. Depends on gsa_pkg.
`default_nettype none

module gsa_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire gsa_pkg::t_sts i_sts,
    output gsa_pkg::t_cmd      o_cmd
);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_DECODE = 7'b0000100,
        S_APICK  = 7'b0001000,
        S_AGEN   = 7'b0010000,
        S_HCHK   = 7'b0100000,
        S_RESP   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Advance the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.is_alloc) begin
                    if (i_sts.any_free) begin
                        o_cmd.rd_alloc = 1'b1;
                        n_state        = S_APICK;
                    end else begin
                        o_cmd.set_full = 1'b1;
                        n_state        = S_RESP;
                    end
                end else if (i_sts.range_bad) begin
                    o_cmd.set_range = 1'b1;
                    n_state         = S_RESP;
                end else begin
                    o_cmd.rd_handle = 1'b1;
                    n_state         = S_HCHK;
                end
            end
            S_APICK: begin
                o_cmd.take_slot = 1'b1;
                n_state         = S_AGEN;
            end
            S_AGEN: begin
                o_cmd.alloc_done = 1'b1;
                n_state          = S_RESP;
            end
            S_HCHK: begin
                o_cmd.chk_handle = 1'b1;
                n_state          = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.push_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Accepts happen only in idle, after the clearing pass
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (r_state == S_IDLE))
        else $error("ready outside idle");

    // A loaded request is decoded in the following cycle
    a_load_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_DECODE))
        else $error("load not followed by decode");

    // Slot claim always follows a free-word read
    a_take_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take_slot |-> $past(o_cmd.rd_alloc))
        else $error("slot claimed without word read");

endmodule

`default_nettype wire

[rtl/gsa_dpath.sv]
// Datapath of the slot allocator: free-map word RAM with per-word summary,
// generation RAM, request and result registers. Depends on gsa_pkg, gsa_ram.
`default_nettype none

module gsa_dpath (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire gsa_pkg::t_cmd                       i_cmd,
    output gsa_pkg::t_sts                            o_sts,
    input  wire logic [gsa_pkg::MODE_W-1:0]          i_mode,
    input  wire logic [gsa_pkg::IN_IDX_W-1:0]        i_slot_index,
    input  wire logic [gsa_pkg::IN_GEN_W-1:0]        i_expected_generation,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [gsa_pkg::STATUS_W-1:0]             o_status,
    output logic [gsa_pkg::RES_IDX_W-1:0]            o_result_index,
    output logic [gsa_pkg::RES_GEN_W-1:0]            o_result_generation,
    output logic                                     o_handle_valid
);

    // Lowest set bit within a free word
    function automatic logic [gsa_pkg::BIT_W-1:0] f_low_bit(
        input logic [gsa_pkg::WORD_W-1:0] v
    );
        logic [gsa_pkg::BIT_W-1:0] idx;
        idx = '0;
        for (int i = gsa_pkg::WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = gsa_pkg::BIT_W'(i);
            end
        end
        return idx;
    endfunction

    // Lowest word that still holds a free slot
    function automatic logic [gsa_pkg::WORD_AW-1:0] f_low_word(
        input logic [gsa_pkg::WORD_CNT-1:0] v
    );
        logic [gsa_pkg::WORD_AW-1:0] idx;
        idx = '0;
        for (int i = gsa_pkg::WORD_CNT - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = gsa_pkg::WORD_AW'(i);
            end
        end
        return idx;
    endfunction

    // Request registers
    logic [gsa_pkg::MODE_W-1:0]   r_mode;
    logic [gsa_pkg::IN_IDX_W-1:0] r_idx;
    logic [gsa_pkg::IN_GEN_W-1:0] r_gen_exp;

    // Clearing pass, summary, claimed slot
    logic [gsa_pkg::IDX_W-1:0]    r_clr_cnt;
    logic [gsa_pkg::WORD_CNT-1:0] r_summary;
    logic [gsa_pkg::WORD_CNT-1:0] n_summary;
    logic [gsa_pkg::WORD_AW-1:0]  r_word_sel;
    logic [gsa_pkg::IDX_W-1:0]    r_slot;

    // Pending result and output register
    logic [gsa_pkg::STATUS_W-1:0]  r_res_status;
    logic [gsa_pkg::RES_IDX_W-1:0] r_res_index;
    logic [gsa_pkg::RES_GEN_W-1:0] r_res_gen;
    logic                          r_res_valid;
    logic                          r_out_valid;
    logic [gsa_pkg::STATUS_W-1:0]  r_out_status;
    logic [gsa_pkg::RES_IDX_W-1:0] r_out_index;
    logic [gsa_pkg::RES_GEN_W-1:0] r_out_gen;
    logic                          r_out_hvalid;

    // RAM ports
    logic                         fw_we;
    logic [gsa_pkg::WORD_AW-1:0]  fw_waddr;
    logic [gsa_pkg::WORD_W-1:0]   fw_wdata;
    logic                         fw_re;
    logic [gsa_pkg::WORD_AW-1:0]  fw_raddr;
    logic [gsa_pkg::WORD_W-1:0]   fw_rdata;
    logic                         gn_we;
    logic [gsa_pkg::IDX_W-1:0]    gn_waddr;
    logic [gsa_pkg::GEN_BITS-1:0] gn_wdata;
    logic                         gn_re;
    logic [gsa_pkg::IDX_W-1:0]    gn_raddr;
    logic [gsa_pkg::GEN_BITS-1:0] gn_rdata;

    // Derived values
    logic [gsa_pkg::IDX_W-1:0]   h_slot;
    logic [gsa_pkg::WORD_AW-1:0] h_word;
    logic [gsa_pkg::BIT_W-1:0]   h_bit;
    logic [gsa_pkg::BIT_W-1:0]   a_bit;
    logic [gsa_pkg::WORD_W-1:0]  a_mask;
    logic [gsa_pkg::WORD_W-1:0]  h_mask;
    logic [gsa_pkg::WORD_W-1:0]  a_word_new;
    logic                        h_live;
    logic                        h_release;

    assign h_slot    = r_idx[gsa_pkg::IDX_W-1:0];
    assign h_word    = gsa_pkg::WORD_AW'(h_slot >> gsa_pkg::BIT_W);
    assign h_bit     = h_slot[gsa_pkg::BIT_W-1:0];
    assign a_bit     = f_low_bit(fw_rdata);
    assign a_mask    = gsa_pkg::WORD_W'(1) << a_bit;
    assign h_mask    = gsa_pkg::WORD_W'(1) << h_bit;
    assign a_word_new = fw_rdata & ~a_mask;
    // Live: slot in use and generation matches
    assign h_live    = ((fw_rdata & h_mask) == '0) &&
                       (gn_rdata == gsa_pkg::GEN_BITS'(r_gen_exp));
    assign h_release = i_cmd.chk_handle && h_live && (r_mode == gsa_pkg::MODE_FREE);

    // Status toward the controller
    assign o_sts.clear_last = (r_clr_cnt == gsa_pkg::IDX_W'(gsa_pkg::SLOT_COUNT - 1));
    assign o_sts.is_alloc   = (r_mode == gsa_pkg::MODE_ALLOC);
    assign o_sts.range_bad  = ({1'b0, r_idx} >=
                               (gsa_pkg::IDX_EXT_W)'(gsa_pkg::SLOT_COUNT));
    assign o_sts.any_free   = (r_summary != '0);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    // Free-map word RAM access
    always_comb begin
        fw_we    = 1'b0;
        fw_waddr = r_word_sel;
        fw_wdata = a_word_new;
        if (i_cmd.clear) begin
            fw_we    = 1'b1;
            fw_waddr = gsa_pkg::WORD_AW'(r_clr_cnt >> gsa_pkg::BIT_W);
            fw_wdata = '1;
        end else if (i_cmd.take_slot) begin
            fw_we = 1'b1;
        end else if (h_release) begin
            fw_we    = 1'b1;
            fw_waddr = h_word;
            fw_wdata = fw_rdata | h_mask;
        end
    end

    assign fw_re    = i_cmd.rd_alloc || i_cmd.rd_handle;
    assign fw_raddr = i_cmd.rd_alloc ? f_low_word(r_summary) : h_word;

    // Generation RAM access
    always_comb begin
        gn_we    = 1'b0;
        gn_waddr = h_slot;
        gn_wdata = gn_rdata + gsa_pkg::GEN_BITS'(1);
        if (i_cmd.clear) begin
            gn_we    = 1'b1;
            gn_waddr = r_clr_cnt;
            gn_wdata = '0;
        end else if (h_release) begin
            gn_we = 1'b1;
        end
    end

    assign gn_re    = i_cmd.rd_handle || i_cmd.take_slot;
    assign gn_raddr = i_cmd.take_slot ? {r_word_sel, a_bit} : h_slot;

    gsa_ram #(
        .WIDTH (gsa_pkg::WORD_W),
        .DEPTH (gsa_pkg::WORD_CNT)
    ) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (fw_we),
        .i_waddr (fw_waddr),
        .i_wdata (fw_wdata),
        .i_re    (fw_re),
        .i_raddr (fw_raddr),
        .o_rdata (fw_rdata)
    );

    gsa_ram #(
        .WIDTH (gsa_pkg::GEN_BITS),
        .DEPTH (gsa_pkg::SLOT_COUNT)
    ) u_gen_ram (
        .i_clk   (i_clk),
        .i_we    (gn_we),
        .i_waddr (gn_waddr),
        .i_wdata (gn_wdata),
        .i_re    (gn_re),
        .i_raddr (gn_raddr),
        .o_rdata (gn_rdata)
    );

    // Summary update: drop a word that ran out, mark a word that got a slot back
    always_comb begin
        n_summary = r_summary;
        if (i_cmd.take_slot) begin
            n_summary[r_word_sel] = (a_word_new != '0);
        end else if (h_release) begin
            n_summary[h_word] = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt   <= '0;
            r_summary   <= '1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_cnt <= r_clr_cnt + gsa_pkg::IDX_W'(1);
            end
            r_summary <= n_summary;
            if (i_cmd.push_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request capture and claimed slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode    <= i_mode;
            r_idx     <= i_slot_index;
            r_gen_exp <= i_expected_generation;
        end
        if (i_cmd.rd_alloc) begin
            r_word_sel <= f_low_word(r_summary);
        end
        if (i_cmd.take_slot) begin
            r_slot <= {r_word_sel, a_bit};
        end
    end

    // Result assembly
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_full) begin
            r_res_status <= gsa_pkg::ST_FULL;
            r_res_index  <= '0;
            r_res_gen    <= '0;
            r_res_valid  <= 1'b0;
        end else if (i_cmd.set_range) begin
            r_res_status <= gsa_pkg::ST_RANGE;
            r_res_index  <= gsa_pkg::RES_IDX_W'(r_idx);
            r_res_gen    <= '0;
            r_res_valid  <= 1'b0;
        end else if (i_cmd.alloc_done) begin
            r_res_status <= gsa_pkg::ST_OK;
            r_res_index  <= gsa_pkg::RES_IDX_W'(r_slot);
            r_res_gen    <= gsa_pkg::RES_GEN_W'(gn_rdata);
            r_res_valid  <= 1'b0;
        end else if (i_cmd.chk_handle) begin
            r_res_status <= h_live ? gsa_pkg::ST_OK : gsa_pkg::ST_STALE;
            r_res_index  <= gsa_pkg::RES_IDX_W'(r_idx);
            r_res_gen    <= '0;
            r_res_valid  <= h_live;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.push_out) begin
            r_out_status <= r_res_status;
            r_out_index  <= r_res_index;
            r_out_gen    <= r_res_gen;
            r_out_hvalid <= r_res_valid;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_status            = r_out_status;
    assign o_result_index      = r_out_index;
    assign o_result_generation = r_out_gen;
    assign o_handle_valid      = r_out_hvalid;

    // Summary promised a free bit, so the word read for a claim is not empty
    a_claim_word_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take_slot |-> (fw_rdata != '0))
        else $error("summary and free map disagree");

    // Out of slots only when the summary is empty
    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.set_full |-> (r_summary == '0))
        else $error("full reported with free words");

    // A released slot's word shows free in the summary afterwards
    a_release_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        h_release |=> r_summary[h_word])
        else $error("released slot missing from summary");

    // Result enters the output register only when it is empty or draining
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push_out |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten");

endmodule

`default_nettype wire

[rtl/generational_slot_allocator.sv]
// Top level of the generational slot allocator: stream ports, controller
// and datapath. Depends on gsa_pkg, gsa_ctrl, gsa_dpath (and gsa_ram below).
//
//  Channel   Direction  Handshake                    Content
//  s_axis    in         i_s_axis_tvalid/o_..._tready  request: mode, slot index, generation
//  m_axis    out        o_m_axis_tvalid/i_..._tready  result: status, index, generation, live
//
// One request at a time. Allocate goes through decode with the summary pick and
// free-word RAM read, then the slot claim with the generation RAM read, then
// the result latch; free and check read both RAMs, then judge the handle; a
// full table or a bad index is settled in decode. The result moves into the
// output register once it has room, and then the next request can be accepted.
// After reset a clearing pass over all SLOT_COUNT (1024) slots writes both RAMs;
// no request is accepted meanwhile. A stalled result waits in the output
// register while the next request is taken in.
`default_nettype none

module generational_slot_allocator (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // [15:0] slot_index, [31:16] expected_generation
    input  wire logic [gsa_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // [1:0] mode
    input  wire logic [gsa_pkg::IN_TUSER_W-1:0]     i_s_axis_tuser,
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // [9:0] result_index, [25:10] result_generation, [31:26] zero
    output logic [gsa_pkg::OUT_TDATA_W-1:0]         o_m_axis_tdata,
    // [1:0] status, [2] handle_valid
    output logic [gsa_pkg::OUT_TUSER_W-1:0]         o_m_axis_tuser
);

    gsa_pkg::t_cmd cmd;
    gsa_pkg::t_sts sts;

    logic [gsa_pkg::STATUS_W-1:0]  status;
    logic [gsa_pkg::RES_IDX_W-1:0] result_index;
    logic [gsa_pkg::RES_GEN_W-1:0] result_generation;
    logic                          handle_valid;

    gsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    gsa_dpath u_dpath (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .o_sts                 (sts),
        .i_mode                (i_s_axis_tuser[gsa_pkg::MODE_W-1:0]),
        .i_slot_index          (i_s_axis_tdata[gsa_pkg::IN_IDX_W-1:0]),
        .i_expected_generation (i_s_axis_tdata[gsa_pkg::IN_IDX_W +: gsa_pkg::IN_GEN_W]),
        .o_out_valid           (o_m_axis_tvalid),
        .i_out_ready           (i_m_axis_tready),
        .o_status              (status),
        .o_result_index        (result_index),
        .o_result_generation   (result_generation),
        .o_handle_valid        (handle_valid)
    );

    // Pack result fields, lowest field first
    assign o_m_axis_tdata = gsa_pkg::OUT_TDATA_W'({result_generation, result_index});
    assign o_m_axis_tuser = {handle_valid, status};

endmodule

`default_nettype wire
